FILE: rtl/ps2d_pkg.sv
// ps2d_pkg: constants, request structs and table address helper for the
// ps/2 set-2 scan code decoder; no dependencies
package ps2d_pkg;

  localparam int KEY_COUNT   = 132;
  localparam int TABLE_DEPTH = 4 * KEY_COUNT;
  localparam int ADDR_W      = $clog2(TABLE_DEPTH);

  localparam logic [7:0] CODE_BREAK  = 8'hF0;
  localparam logic [7:0] CODE_EXTEND = 8'hE0;
  localparam logic [7:0] CODE_LSHIFT = 8'h12;
  localparam logic [7:0] CODE_RSHIFT = 8'h59;
  localparam logic [7:0] CODE_CTRL   = 8'h14;
  localparam logic [7:0] CODE_ALTGR  = 8'h11;
  localparam logic [7:0] CODE_CAPS   = 8'h58;
  localparam logic [7:0] CODE_NONE   = 8'h00;

  localparam logic CMD_DECODE = 1'b0;
  localparam logic CMD_WRITE  = 1'b1;

  localparam logic [1:0] PLANE_NORMAL = 2'd0;
  localparam logic [1:0] PLANE_SHIFT  = 2'd1;
  localparam logic [1:0] PLANE_ALTGR  = 2'd2;
  localparam logic [1:0] PLANE_EXT    = 2'd3;

  localparam int FLAG_LSHIFT = 0;
  localparam int FLAG_RSHIFT = 1;
  localparam int FLAG_ALTGR  = 2;
  localparam int FLAG_CTRL   = 3;
  localparam int FLAG_CAPS   = 4;

  localparam logic [7:0] CHAR_LA = 8'h61;
  localparam logic [7:0] CHAR_LZ = 8'h7A;
  localparam logic [7:0] CHAR_UA = 8'h41;
  localparam logic [7:0] CHAR_UZ = 8'h5A;
  localparam logic [7:0] CASE_OFFSET = 8'h20;
  localparam logic [7:0] CTRL_UPPER  = 8'h40;
  localparam logic [7:0] CTRL_LOWER  = 8'h60;

  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
    logic [7:0]        data;
  } tbl_wr_t;

  typedef struct packed {
    logic       valid;
    logic       use_ext;
    logic       in_range;
    logic       caps;
    logic       ctrl;
    logic [1:0] plane;
    logic [7:0] idx;
  } lk_req_t;

  function automatic logic [ADDR_W-1:0] key_addr(input logic [1:0] plane,
                                                  input logic [7:0] idx);
    logic [ADDR_W+1:0] full;
    full = (ADDR_W+2)'(plane) * (ADDR_W+2)'(KEY_COUNT) + (ADDR_W+2)'(idx);
    return full[ADDR_W-1:0];
  endfunction

endpackage

FILE: rtl/ps2d_flags.sv
// ps2d_flags: prefix and modifier flag registers, decodes requests into
// table writes and table lookups; depends on ps2d_pkg
module ps2d_flags (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               accept,
  input  logic               command,
  input  logic [7:0]         scan_code,
  input  logic [1:0]         table_plane,
  input  logic [7:0]         table_index,
  input  logic [7:0]         table_value,
  output ps2d_pkg::tbl_wr_t  wr,
  output ps2d_pkg::lk_req_t  req
);

  logic       break_r, break_nxt;
  logic       ext_r, ext_nxt;
  logic [4:0] mods_r, mods_nxt;

  always_comb begin
    break_nxt = break_r;
    ext_nxt   = ext_r;
    mods_nxt  = mods_r;
    wr        = '0;
    req       = '0;
    wr.addr   = ps2d_pkg::key_addr(table_plane, table_index);
    wr.data   = table_value;
    req.idx   = scan_code;
    req.in_range = int'(scan_code) < ps2d_pkg::KEY_COUNT;
    req.use_ext  = ext_r;
    req.caps     = mods_r[ps2d_pkg::FLAG_CAPS];
    req.ctrl     = mods_r[ps2d_pkg::FLAG_CTRL];
    if (mods_r[ps2d_pkg::FLAG_ALTGR]) begin
      req.plane = ps2d_pkg::PLANE_ALTGR;
    end else if (mods_r[ps2d_pkg::FLAG_LSHIFT] || mods_r[ps2d_pkg::FLAG_RSHIFT]) begin
      req.plane = ps2d_pkg::PLANE_SHIFT;
    end else begin
      req.plane = ps2d_pkg::PLANE_NORMAL;
    end
    if (accept) begin
      if (command == ps2d_pkg::CMD_WRITE) begin
        wr.en = int'(table_index) < ps2d_pkg::KEY_COUNT;
      end else if (scan_code == ps2d_pkg::CODE_NONE) begin
        // ignored
      end else if (scan_code == ps2d_pkg::CODE_BREAK) begin
        break_nxt = 1'b1;
      end else if (scan_code == ps2d_pkg::CODE_EXTEND) begin
        ext_nxt = 1'b1;
      end else begin
        ext_nxt = 1'b0;
        if (break_r) begin
          break_nxt = 1'b0;
          case (scan_code)
            ps2d_pkg::CODE_LSHIFT: mods_nxt[ps2d_pkg::FLAG_LSHIFT] = 1'b0;
            ps2d_pkg::CODE_RSHIFT: mods_nxt[ps2d_pkg::FLAG_RSHIFT] = 1'b0;
            ps2d_pkg::CODE_CTRL:   mods_nxt[ps2d_pkg::FLAG_CTRL] = 1'b0;
            ps2d_pkg::CODE_ALTGR: begin
              if (ext_r) begin
                mods_nxt[ps2d_pkg::FLAG_ALTGR] = 1'b0;
              end
            end
            default: ;
          endcase
        end else if (ext_r && scan_code == ps2d_pkg::CODE_ALTGR) begin
          mods_nxt[ps2d_pkg::FLAG_ALTGR] = 1'b1;
        end else begin
          case (scan_code)
            ps2d_pkg::CODE_CAPS:   mods_nxt[ps2d_pkg::FLAG_CAPS] = ~mods_r[ps2d_pkg::FLAG_CAPS];
            ps2d_pkg::CODE_LSHIFT: mods_nxt[ps2d_pkg::FLAG_LSHIFT] = 1'b1;
            ps2d_pkg::CODE_RSHIFT: mods_nxt[ps2d_pkg::FLAG_RSHIFT] = 1'b1;
            ps2d_pkg::CODE_CTRL:   mods_nxt[ps2d_pkg::FLAG_CTRL] = 1'b1;
            default:               req.valid = 1'b1;
          endcase
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      break_r <= 1'b0;
      ext_r   <= 1'b0;
      mods_r  <= '0;
    end else begin
      break_r <= break_nxt;
      ext_r   <= ext_nxt;
      mods_r  <= mods_nxt;
    end
  end

endmodule

FILE: rtl/ps2d_lookup.sv
// ps2d_lookup: key table memory with two read ports, plane selection,
// caps/ctrl adjustment and the result register; depends on ps2d_pkg
module ps2d_lookup (
  input  logic              clk,
  input  logic              rst_n,
  input  ps2d_pkg::tbl_wr_t wr,
  input  ps2d_pkg::lk_req_t req,
  output logic              ready,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [7:0]        out_character
);

  logic [7:0] mem [ps2d_pkg::TABLE_DEPTH];

  ps2d_pkg::lk_req_t lk_r;
  logic [7:0]        rd_ext_r, rd_base_r;
  logic              out_valid_r;
  logic [7:0]        out_char_r;
  logic              p1_adv, p1_load;
  logic [7:0]        safe_idx;
  logic [ps2d_pkg::ADDR_W-1:0] ext_addr, base_addr;
  logic [7:0]        c_sel, c_caps, c_fin;

  assign p1_adv  = !out_valid_r || !out_stall;
  assign p1_load = !lk_r.valid || p1_adv;
  assign ready   = p1_load;

  assign safe_idx  = req.in_range ? req.idx : 8'd0;
  assign ext_addr  = ps2d_pkg::key_addr(ps2d_pkg::PLANE_EXT, safe_idx);
  assign base_addr = ps2d_pkg::key_addr(req.plane, safe_idx);

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    if (p1_load) begin
      rd_ext_r  <= mem[ext_addr];
      rd_base_r <= mem[base_addr];
    end
  end

  always_comb begin
    if (!lk_r.in_range) begin
      c_sel = 8'd0;
    end else if (lk_r.use_ext && rd_ext_r != 8'd0) begin
      c_sel = rd_ext_r;
    end else begin
      c_sel = rd_base_r;
    end
    c_caps = c_sel;
    if (lk_r.caps && c_sel >= ps2d_pkg::CHAR_LA && c_sel <= ps2d_pkg::CHAR_LZ) begin
      c_caps = c_sel - ps2d_pkg::CASE_OFFSET;
    end
    c_fin = c_caps;
    if (lk_r.ctrl) begin
      if (c_caps >= ps2d_pkg::CHAR_UA && c_caps <= ps2d_pkg::CHAR_UZ) begin
        c_fin = c_caps - ps2d_pkg::CTRL_UPPER;
      end else if (c_caps >= ps2d_pkg::CHAR_LA && c_caps <= ps2d_pkg::CHAR_LZ) begin
        c_fin = c_caps - ps2d_pkg::CTRL_LOWER;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lk_r.valid  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (p1_load) begin
        lk_r.valid <= req.valid;
      end
      if (p1_adv) begin
        out_valid_r <= lk_r.valid && c_fin != 8'd0;
      end
    end
    if (p1_load) begin
      lk_r.use_ext  <= req.use_ext;
      lk_r.in_range <= req.in_range;
      lk_r.caps     <= req.caps;
      lk_r.ctrl     <= req.ctrl;
      lk_r.plane    <= req.plane;
      lk_r.idx      <= req.idx;
    end
    if (p1_adv) begin
      out_char_r <= c_fin;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_character = out_char_r;

  a_no_wr_and_lookup: assert property (@(posedge clk) disable iff (!rst_n)
    !(wr.en && req.valid))
    else $error("table write and lookup in the same cycle");

  a_req_only_when_ready: assert property (@(posedge clk) disable iff (!rst_n)
    (req.valid || wr.en) |-> p1_load)
    else $error("request taken while lookup stage is held");

  a_held_read_stable: assert property (@(posedge clk) disable iff (!rst_n)
    (lk_r.valid && !p1_load) |=> ($stable(rd_ext_r) && $stable(rd_base_r)))
    else $error("read data changed while lookup stage held");

  a_char_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> out_char_r != 8'd0)
    else $error("zero character emitted");

endmodule

FILE: rtl/ps2_scan_code_to_char_decoder.sv
// ps2_scan_code_to_char_decoder: top level of the ps/2 set-2 decoder
// depends on ps2d_pkg, ps2d_flags and ps2d_lookup
//
// Takes one request per clock unless stalled (scan byte to decode or key table
// write) and produces at most one character per scan byte. The prefix and
// modifier flags update at the edge a request is taken; at that same edge key
// presses read the extended plane and the modifier-selected plane of the
// 528-entry key table in parallel, and the adjusted character is loaded into
// the output register when the output is not stalled. A stalled output holds
// the lookup stage and back-pressures the input. Table entries must be written
// before they are read; the table has no reset.
module ps2_scan_code_to_char_decoder (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic       in_command,
  input  logic [7:0] in_scan_code,
  input  logic [1:0] in_table_plane,
  input  logic [7:0] in_table_index,
  input  logic [7:0] in_table_value,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_character
);

  logic              ready;
  logic              accept;
  ps2d_pkg::tbl_wr_t wr;
  ps2d_pkg::lk_req_t req;

  assign in_stall = !ready;
  assign accept   = in_valid && ready;

  ps2d_flags u_flags (
    .clk         (clk),
    .rst_n       (rst_n),
    .accept      (accept),
    .command     (in_command),
    .scan_code   (in_scan_code),
    .table_plane (in_table_plane),
    .table_index (in_table_index),
    .table_value (in_table_value),
    .wr          (wr),
    .req         (req)
  );

  ps2d_lookup u_lookup (
    .clk           (clk),
    .rst_n         (rst_n),
    .wr            (wr),
    .req           (req),
    .ready         (ready),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_character (out_character)
  );

endmodule
